FILE: src/sm2_pkg.sv
package sm2_pkg;

   localparam int LimbWidth = 64;
   localparam int FieldWidth = 256;
   localparam int ProdWidth = 512;
   localparam int QueueDepthDefault = 4;

   localparam logic [FieldWidth-1:0] Prime =
      256'hFFFFFFFEFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFF00000000_FFFFFFFFFFFFFFFF;
   localparam logic [FieldWidth-1:0] ExpPm2 =
      256'hFFFFFFFEFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFF00000000_FFFFFFFFFFFFFFFD;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_NEG = 3'd2,
      OP_MUL = 3'd3,
      OP_SQR = 3'd4,
      OP_INV = 3'd5,
      OP_NOP6 = 3'd6,
      OP_NOP7 = 3'd7
   } opcode_type;

   // kind of work the back end does for one queued request
   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_MUL = 2'd1,
      KIND_INV = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [FieldWidth-1:0] x;
      logic [FieldWidth-1:0] y;
   } job_type;

   // one conditional subtraction of p, input below 2p
   function automatic logic [FieldWidth-1:0] reduce_once(
      input logic [FieldWidth:0] v);
      logic [FieldWidth:0] d;
      d = v - {1'b0, Prime};
      reduce_once = d[FieldWidth] ? v[FieldWidth-1:0] : d[FieldWidth-1:0];
   endfunction

endpackage

FILE: src/sm2_prime_field_alu.sv
// SM2 prime field ALU, p = 2^256 - 2^224 - 2^96 + 2^64 - 1.
// Request channel: req_valid/req_stall with req_opcode and operand limbs.
// Response channel: rsp_valid/rsp_stall with r_limb0..3, one per request,
// in request order. Operands at or above p are reduced first.
// Add, subtract, negate and undefined opcodes are finished in the front
// stage, one per cycle when the back end is idle and the response side flows.
// Multiply and square use one shared 32x32 multiplier stepped over 64
// partial products, each multiplied and then accumulated, plus fold steps;
// the back end takes a new one only once the last is done, so this
// multiplier sets the rate for those ops. Inversion runs 256 squarings and
// 222 multiplies for the set exponent bits on the same unit.
// A request queue decouples the front from the back end; req_stall rises
// when the queue is close to full, and a stalled response holds its data
// while the back end stops taking work. Reset empties queue and pipeline.
module sm2_prime_field_alu #(
   parameter int QueueDepth = sm2_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [63:0] req_a_limb0,
   input  logic [63:0] req_a_limb1,
   input  logic [63:0] req_a_limb2,
   input  logic [63:0] req_a_limb3,
   input  logic [63:0] req_b_limb0,
   input  logic [63:0] req_b_limb1,
   input  logic [63:0] req_b_limb2,
   input  logic [63:0] req_b_limb3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_r_limb0,
   output logic [63:0] rsp_r_limb1,
   output logic [63:0] rsp_r_limb2,
   output logic [63:0] rsp_r_limb3
);

   logic                       acc;
   logic                       fv;
   sm2_pkg::job_type           fjob, head;
   logic                       pop, nempty;
   logic [$clog2(QueueDepth+1)-1:0] cnt;
   logic [255:0]               rr;

   // leave room for the entry in flight in the front register
   assign req_stall = ({1'b0, cnt} + (fv ? 2'd1 : 2'd0))
                      >= ($clog2(QueueDepth+1)+1)'(QueueDepth - 1);
   assign acc = req_valid && !req_stall;

   sm2_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc),
      .in_op     (sm2_pkg::opcode_type'(req_opcode)),
      .in_a      ({req_a_limb3, req_a_limb2, req_a_limb1, req_a_limb0}),
      .in_b      ({req_b_limb3, req_b_limb2, req_b_limb1, req_b_limb0}),
      .job_valid (fv),
      .job       (fjob)
   );

   sm2_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fv),
      .push_data (fjob),
      .pop       (pop),
      .not_empty (nempty),
      .count     (cnt),
      .head      (head)
   );

   sm2_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (nempty),
      .job       (head),
      .job_pop   (pop),
      .out_valid (rsp_valid),
      .out_r     (rr),
      .out_stall (rsp_stall)
   );

   assign rsp_r_limb0 = rr[63:0];
   assign rsp_r_limb1 = rr[127:64];
   assign rsp_r_limb2 = rr[191:128];
   assign rsp_r_limb3 = rr[255:192];

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> nempty) else $error("queue pop while empty");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(fv && !pop && cnt == ($clog2(QueueDepth+1))'(QueueDepth)))
      else $error("queue overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rr))
      else $error("stalled response changed");
`endif

endmodule

FILE: src/sm2_front.sv
module sm2_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  sm2_pkg::opcode_type           in_op,
   input  logic [sm2_pkg::FieldWidth-1:0] in_a,
   input  logic [sm2_pkg::FieldWidth-1:0] in_b,
   output logic                          job_valid,
   output sm2_pkg::job_type              job
);

   logic                          job_valid_ff;
   sm2_pkg::job_type              job_ff;
   sm2_pkg::job_type              job_in;
   logic [sm2_pkg::FieldWidth-1:0] a_r, b_r;
   logic [sm2_pkg::FieldWidth:0]   sum, dif;

   always_comb begin
      a_r = sm2_pkg::reduce_once({1'b0, in_a});
      b_r = sm2_pkg::reduce_once({1'b0, in_b});
      sum = {1'b0, a_r} + {1'b0, b_r};
      dif = {1'b0, a_r} - {1'b0, b_r};
      job_in.kind = sm2_pkg::KIND_DIRECT;
      job_in.x = '0;
      job_in.y = '0;
      case (in_op)
         sm2_pkg::OP_ADD: job_in.x = sm2_pkg::reduce_once(sum);
         sm2_pkg::OP_SUB: job_in.x = dif[sm2_pkg::FieldWidth] ?
            dif[sm2_pkg::FieldWidth-1:0] + sm2_pkg::Prime : dif[sm2_pkg::FieldWidth-1:0];
         sm2_pkg::OP_NEG: job_in.x = (a_r == '0) ? '0 : sm2_pkg::Prime - a_r;
         sm2_pkg::OP_MUL: begin
            job_in.kind = sm2_pkg::KIND_MUL;
            job_in.x = a_r;
            job_in.y = b_r;
         end
         sm2_pkg::OP_SQR: begin
            job_in.kind = sm2_pkg::KIND_MUL;
            job_in.x = a_r;
            job_in.y = a_r;
         end
         sm2_pkg::OP_INV: begin
            job_in.kind = sm2_pkg::KIND_INV;
            job_in.x = a_r;
         end
         default: job_in.kind = sm2_pkg::KIND_DIRECT;
      endcase
   end

   // one register stage; the queue behind it always has room for this entry
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= in_valid;
      end
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job = job_ff;

endmodule

FILE: src/sm2_queue.sv
module sm2_queue #(
   parameter int Depth = sm2_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sm2_pkg::job_type push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [$clog2(Depth+1)-1:0] count,
   output sm2_pkg::job_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

   sm2_pkg::job_type          mem_ff [Depth];
   logic [PtrW-1:0]           wr_ff, wr_in, rd_ff, rd_in;
   logic [$clog2(Depth+1)-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign count = cnt_ff;
   assign head = mem_ff[rd_ff];

endmodule

FILE: src/sm2_mulred.sv
// Modular multiply: 64 steps of one 32x32 partial product, each a multiply
// followed by a shift and accumulate into a 512-bit sum, then fold steps
// until the upper half is zero, then one conditional subtraction of p.
module sm2_mulred (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sm2_pkg::FieldWidth-1:0] x,
   input  logic [sm2_pkg::FieldWidth-1:0] y,
   output logic                           done,
   output logic [sm2_pkg::FieldWidth-1:0] result
);

   localparam int FW = sm2_pkg::FieldWidth;
   localparam int PW = sm2_pkg::ProdWidth;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_FOLD = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [FW-1:0]    x_ff, y_ff;
   logic [PW-1:0]    acc_ff, acc_in;
   logic [31:0]      m_a, m_b;
   logic [63:0]      pp_ff;
   logic [5:0]       step_ff, step_in;
   logic [FW-1:0]    res_ff, res_in;
   logic [1:0]       i_sel, j_sel;
   logic [8:0]       shamt;
   logic [PW-1:0]    fold;
   logic             done_ff;

   // step encodes limb pair (4 bits) and 32-bit quarter (2 bits)
   assign i_sel = step_ff[5:4];
   assign j_sel = step_ff[3:2];
   assign shamt = {1'b0, i_sel, 6'd0} + {1'b0, j_sel, 6'd0}
                + {3'd0, step_ff[1], 5'd0} + {3'd0, step_ff[0], 5'd0};

   always_comb begin
      m_a = step_ff[1] ? x_ff[64*i_sel+32 +: 32] : x_ff[64*i_sel +: 32];
      m_b = step_ff[0] ? y_ff[64*j_sel+32 +: 32] : y_ff[64*j_sel +: 32];
   end

   // hi * (2^224 + 2^96 - 2^64 + 1) + lo
   always_comb begin
      fold = {256'd0, acc_ff[FW-1:0]}
           + {{(PW-FW){1'b0}}, acc_ff[PW-1:FW]}
           + ({{(PW-FW){1'b0}}, acc_ff[PW-1:FW]} << 224)
           + ({{(PW-FW){1'b0}}, acc_ff[PW-1:FW]} << 96)
           - ({{(PW-FW){1'b0}}, acc_ff[PW-1:FW]} << 64);
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
               step_in = '0;
               acc_in = '0;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            acc_in = acc_ff + ({{(PW-64){1'b0}}, pp_ff} << shamt);
            if (step_ff == 6'd63) begin
               state_in = ST_FOLD;
            end else begin
               step_in = step_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_FOLD: begin
            if (acc_ff[PW-1:FW] == '0) begin
               state_in = ST_FIN;
            end else begin
               acc_in = fold;
            end
         end
         ST_FIN: begin
            res_in = sm2_pkg::reduce_once({1'b0, acc_ff[FW-1:0]});
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= (state_ff == ST_FIN);
      end
      if (state_ff == ST_IDLE && start) begin
         x_ff <= x;
         y_ff <= y;
      end
      pp_ff <= {32'd0, m_a} * {32'd0, m_b};
      step_ff <= step_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign result = res_ff;

endmodule

FILE: src/sm2_back.sv
module sm2_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   input  sm2_pkg::job_type               job,
   output logic                           job_pop,
   output logic                           out_valid,
   output logic [sm2_pkg::FieldWidth-1:0] out_r,
   input  logic                           out_stall
);

   localparam int FW = sm2_pkg::FieldWidth;

   typedef enum logic [3:0] {
      BK_IDLE = 4'b0001,
      BK_MUL  = 4'b0010,
      BK_INV  = 4'b0100,
      BK_OUT  = 4'b1000
   } bstate_type;

   bstate_type      st_ff, st_in;
   logic            mstart;
   logic [FW-1:0]   mx, my, mres;
   logic            mdone;
   logic [FW-1:0]   base_ff, acc_ff, acc_in;
   logic [7:0]      bit_ff, bit_in;
   logic            sq_ff, sq_in, go_ff, go_in;
   logic            ov_ff, ov_in;
   logic [FW-1:0]   r_ff, r_in;

   sm2_mulred u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mstart),
      .x      (mx),
      .y      (my),
      .done   (mdone),
      .result (mres)
   );

   logic out_free;
   assign out_free = !ov_ff || !out_stall;

   always_comb begin
      st_in = st_ff;
      acc_in = acc_ff;
      bit_in = bit_ff;
      sq_in = sq_ff;
      go_in = 1'b0;
      ov_in = ov_ff && out_stall;
      r_in = r_ff;
      job_pop = 1'b0;
      mstart = 1'b0;
      mx = acc_ff;
      my = acc_ff;
      case (st_ff)
         BK_IDLE: begin
            if (job_valid && out_free) begin
               job_pop = 1'b1;
               case (job.kind)
                  sm2_pkg::KIND_MUL: begin
                     mstart = 1'b1;
                     mx = job.x;
                     my = job.y;
                     st_in = BK_MUL;
                  end
                  sm2_pkg::KIND_INV: begin
                     acc_in = {{(FW-1){1'b0}}, 1'b1};
                     bit_in = 8'd255;
                     sq_in = 1'b1;
                     go_in = 1'b1;
                     st_in = BK_INV;
                  end
                  default: begin
                     ov_in = 1'b1;
                     r_in = job.x;
                  end
               endcase
            end
         end
         BK_MUL: begin
            if (mdone) begin
               ov_in = 1'b1;
               r_in = mres;
               st_in = BK_IDLE;
            end
         end
         BK_INV: begin
            if (go_ff) begin
               mstart = 1'b1;
               my = sq_ff ? acc_ff : base_ff;
            end else if (mdone) begin
               acc_in = mres;
               if (sq_ff && sm2_pkg::ExpPm2[bit_ff]) begin
                  sq_in = 1'b0;
                  go_in = 1'b1;
               end else if (bit_ff == 8'd0) begin
                  st_in = BK_OUT;
               end else begin
                  bit_in = bit_ff - 1'b1;
                  sq_in = 1'b1;
                  go_in = 1'b1;
               end
            end
         end
         BK_OUT: begin
            if (out_free) begin
               ov_in = 1'b1;
               r_in = acc_ff;
               st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         ov_ff <= 1'b0;
         go_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         go_ff <= go_in;
      end
      if (st_ff == BK_IDLE && job_pop) begin
         base_ff <= job.x;
      end
      acc_ff <= acc_in;
      bit_ff <= bit_in;
      sq_ff <= sq_in;
      r_ff <= r_in;
   end

   assign out_valid = ov_ff;
   assign out_r = r_ff;

endmodule

FILE: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [sm2_pkg::FieldWidth-1:0] field_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [63:0] req_a_limb0, req_a_limb1, req_a_limb2, req_a_limb3;
   logic [63:0] req_b_limb0, req_b_limb1, req_b_limb2, req_b_limb3;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_r_limb0, rsp_r_limb1, rsp_r_limb2, rsp_r_limb3;

   field_type expected_residues[$];
   int     mismatch_count;
   int     send_idle_pct;
   int     recv_stall_pct;
   int     hold_off_cycles;
   int     inv_budget;

   sm2_prime_field_alu DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_a_limb0(req_a_limb0), .req_a_limb1(req_a_limb1),
      .req_a_limb2(req_a_limb2), .req_a_limb3(req_a_limb3),
      .req_b_limb0(req_b_limb0), .req_b_limb1(req_b_limb1),
      .req_b_limb2(req_b_limb2), .req_b_limb3(req_b_limb3),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_r_limb0(rsp_r_limb0), .rsp_r_limb1(rsp_r_limb1),
      .rsp_r_limb2(rsp_r_limb2), .rsp_r_limb3(rsp_r_limb3)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic field_type mod_mul(field_type x, field_type y);
      logic [sm2_pkg::ProdWidth-1:0] prod;
      prod = {256'b0, x} * {256'b0, y};
      prod = prod % {256'b0, sm2_pkg::Prime};
      return prod[sm2_pkg::FieldWidth-1:0];
   endfunction

   function automatic field_type field_result(logic [2:0] op, field_type a, field_type b);
      logic [sm2_pkg::FieldWidth:0] sum;
      field_type acc;
      // operands at or above p wrap once
      if (a >= sm2_pkg::Prime) a = a - sm2_pkg::Prime;
      if (b >= sm2_pkg::Prime) b = b - sm2_pkg::Prime;
      case (op)
         sm2_pkg::OP_ADD: begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum >= {1'b0, sm2_pkg::Prime}) sum = sum - {1'b0, sm2_pkg::Prime};
            return sum[sm2_pkg::FieldWidth-1:0];
         end
         sm2_pkg::OP_SUB: return (a >= b) ? a - b : a + (sm2_pkg::Prime - b);
         sm2_pkg::OP_NEG: return (a == '0) ? '0 : sm2_pkg::Prime - a;
         sm2_pkg::OP_MUL: return mod_mul(a, b);
         sm2_pkg::OP_SQR: return mod_mul(a, a);
         sm2_pkg::OP_INV: begin
            acc = 256'd1;
            for (int i = sm2_pkg::FieldWidth - 1; i >= 0; i--) begin
               acc = mod_mul(acc, acc);
               if (sm2_pkg::ExpPm2[i]) acc = mod_mul(acc, a);
            end
            return acc;
         end
         default: return '0;
      endcase
   endfunction

   function automatic field_type rand_operand();
      field_type v;
      for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
      case ($urandom_range(9))
         0: v = field_type'($urandom_range(3));
         1: v = sm2_pkg::Prime - field_type'($urandom_range(1, 3));
         2: v = sm2_pkg::Prime + field_type'($urandom_range(3));
         3: v = '1;
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_request(logic [2:0] op, field_type a, field_type b);
      bit accepted;
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      {req_a_limb3, req_a_limb2, req_a_limb1, req_a_limb0} <= a;
      {req_b_limb3, req_b_limb2, req_b_limb1, req_b_limb0} <= b;
      do begin
         @(negedge clock);
         accepted = !req_stall;
         if (accepted) expected_residues.push_back(field_result(op, a, b));
         @(posedge clock);
      end while (!accepted);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      while (expected_residues.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      field_type pm1;
      pm1 = sm2_pkg::Prime - 1;
      send_request(sm2_pkg::OP_ADD, pm1, pm1);
      send_request(sm2_pkg::OP_ADD, '1, '1);
      send_request(sm2_pkg::OP_ADD, sm2_pkg::Prime, sm2_pkg::Prime);
      send_request(sm2_pkg::OP_ADD, '0, '0);
      send_request(sm2_pkg::OP_SUB, '0, 256'd1);
      send_request(sm2_pkg::OP_SUB, pm1, pm1);
      send_request(sm2_pkg::OP_SUB, '0, '1);
      send_request(sm2_pkg::OP_NEG, '0, '1);
      send_request(sm2_pkg::OP_NEG, 256'd1, '0);
      send_request(sm2_pkg::OP_NEG, sm2_pkg::Prime, '0);
      send_request(sm2_pkg::OP_MUL, pm1, pm1);
      send_request(sm2_pkg::OP_MUL, '0, '1);
      send_request(sm2_pkg::OP_MUL, '1, '1);
      send_request(sm2_pkg::OP_SQR, '1, '0);
      send_request(sm2_pkg::OP_SQR, pm1, '0);
      send_request(sm2_pkg::OP_INV, '0, '1);
      send_request(sm2_pkg::OP_INV, 256'd1, '0);
      send_request(sm2_pkg::OP_INV, rand_operand(), '0);
      send_request(sm2_pkg::OP_NOP6, '1, '1);
      send_request(sm2_pkg::OP_NOP7, pm1, 256'd5);
      go_idle();
   endtask

   // receiver blocks for a long stretch while the sender keeps pushing
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 2000;
      for (int i = 0; i < 24; i++)
         send_request(($urandom_range(1) != 0) ? sm2_pkg::OP_ADD : sm2_pkg::OP_MUL,
                      rand_operand(), rand_operand());
      go_idle();
   endtask

   task automatic test_random(int idle_pct, int stall_pct, int count);
      logic [2:0] op;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(19))
            0, 1, 2:       op = sm2_pkg::OP_ADD;
            3, 4, 5:       op = sm2_pkg::OP_SUB;
            6, 7:          op = sm2_pkg::OP_NEG;
            8, 9, 10, 11:  op = sm2_pkg::OP_MUL;
            12, 13, 14:    op = sm2_pkg::OP_SQR;
            15:            op = ($urandom_range(1) != 0) ? sm2_pkg::OP_NOP6
                                                         : sm2_pkg::OP_NOP7;
            16:            op = (inv_budget > 0 && $urandom_range(30) == 0)
                                ? sm2_pkg::OP_INV : sm2_pkg::OP_MUL;
            default:       op = 3'($urandom_range(sm2_pkg::OP_NEG));
         endcase
         if (op == sm2_pkg::OP_INV) inv_budget--;
         send_request(op, rand_operand(), rand_operand());
      end
      go_idle();
   endtask

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(negedge clock) begin
      field_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_r_limb3, rsp_r_limb2, rsp_r_limb1, rsp_r_limb0};
         if (expected_residues.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_residues.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (got[i*64 +: 64] !== want[i*64 +: 64]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("r_limb%0d mismatch: expected %h actual %h",
                              i, want[i*64 +: 64], got[i*64 +: 64]);
               end
            end
         end
      end
   end

   initial begin
      #30ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      mismatch_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      inv_budget = 3;
      reset <= 1'b1;
      rsp_stall <= 1'b0;
      req_valid <= 1'b0;
      req_opcode <= sm2_pkg::OP_ADD;
      {req_a_limb3, req_a_limb2, req_a_limb1, req_a_limb0} <= '0;
      {req_b_limb3, req_b_limb2, req_b_limb1, req_b_limb0} <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random(0, 0, 100);
      test_random(51, 0, 100);
      test_random(0, 51, 100);
      test_random(36, 36, 100);

      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && expected_residues.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
